>>> src/etfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package etfc_pkg;

    localparam int unsigned CODE_W     = 10;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned INDEX_W    = 15;
    localparam int unsigned POS_W      = 16;
    localparam int unsigned QUIET_W    = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam int unsigned MAX_FRAME_DEFAULT = 32768;

    typedef enum logic [1:0] {
        PH_WAIT_BELOW = 2'd0,
        PH_WAIT_ABOVE = 2'd1,
        PH_CAPTURE    = 2'd2,
        PH_WAIT_QUIET = 2'd3
    } phase_t;

    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH  = 3'd4;

    localparam logic [SAMPLE_W-1:0] TRIGGER_LEVEL_RST = 16'h0000;
    localparam logic [SAMPLE_W-1:0] QUIET_LOW_RST     = 16'hFF00;
    localparam logic [SAMPLE_W-1:0] QUIET_HIGH_RST    = 16'h0100;
    localparam logic [QUIET_W-1:0]  QUIET_COUNT_RST   = 8'd64;
    localparam logic [POS_W-1:0]    FRAME_LENGTH_RST  = 16'd20000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] trigger_level;
        logic [SAMPLE_W-1:0] quiet_low;
        logic [SAMPLE_W-1:0] quiet_high;
        logic [QUIET_W-1:0]  quiet_count_needed;
        logic [POS_W-1:0]    frame_length;
    } cfg_t;

endpackage

`default_nettype wire

>>> src/etfc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module etfc_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [etfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [etfc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output etfc_pkg::cfg_t                           cfg
);

    etfc_pkg::cfg_t cfg_reg;
    etfc_pkg::cfg_t cfg_next;

    // Decode the register index; unknown indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                etfc_pkg::REG_TRIGGER_LEVEL: cfg_next.trigger_level = cfg_data;
                etfc_pkg::REG_QUIET_LOW:     cfg_next.quiet_low     = cfg_data;
                etfc_pkg::REG_QUIET_HIGH:    cfg_next.quiet_high    = cfg_data;
                etfc_pkg::REG_QUIET_COUNT:
                    cfg_next.quiet_count_needed = cfg_data[etfc_pkg::QUIET_W-1:0];
                etfc_pkg::REG_FRAME_LENGTH:  cfg_next.frame_length  = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_level      <= etfc_pkg::TRIGGER_LEVEL_RST;
            cfg_reg.quiet_low          <= etfc_pkg::QUIET_LOW_RST;
            cfg_reg.quiet_high         <= etfc_pkg::QUIET_HIGH_RST;
            cfg_reg.quiet_count_needed <= etfc_pkg::QUIET_COUNT_RST;
            cfg_reg.frame_length       <= etfc_pkg::FRAME_LENGTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> src/edge_triggered_frame_capture.sv
`timescale 1ns / 1ps
`default_nettype none

// Edge-triggered frame capture. Each request carries one 10-bit converter code,
// which becomes the signed sample (code - 512) << 6. The trigger arms on a
// sample below trigger_level, fires on a later sample above it, and then
// marks that sample and the ones after it as capture writes with index 0 up to
// frame_length-1, flagging the last. The sample after a full frame moves the
// block to a silence wait, and quiet_count_needed samples in a row inside
// [quiet_low, quiet_high] rearm it. Every request yields exactly one result,
// in the cycle after it is taken; a new request is taken every cycle as long as
// the output register is empty or being drained, so throughput is one sample
// per clock, bounded only by the single trigger/counter update per sample.
// Write configuration only while no request is in flight. A frame length of
// zero acts as one, and lengths above MAX_FRAME are clamped to MAX_FRAME.

module edge_triggered_frame_capture #(
    parameter int unsigned MAX_FRAME = etfc_pkg::MAX_FRAME_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_wr_en,
    input  wire logic [etfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [etfc_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [etfc_pkg::CODE_W-1:0]        adc_code,

    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    capture_valid,
    output logic [etfc_pkg::INDEX_W-1:0]            capture_index,
    output logic signed [etfc_pkg::SAMPLE_W-1:0]    sample_value,
    output logic                                    frame_last,
    output logic [1:0]                              phase
);

    localparam int unsigned LEN_W = etfc_pkg::POS_W + 1;
    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_FRAME);

    etfc_pkg::cfg_t cfg;

    etfc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Trigger state
    etfc_pkg::phase_t                   phase_reg, phase_next;
    logic [etfc_pkg::QUIET_W-1:0]       quiet_reg, quiet_next;
    logic [etfc_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic                               complete_reg, complete_next;

    // Output register
    logic                               out_valid_reg, out_valid_next;
    logic                               cap_valid_reg, cap_valid_next;
    logic [etfc_pkg::INDEX_W-1:0]       cap_index_reg, cap_index_next;
    logic signed [etfc_pkg::SAMPLE_W-1:0] sample_reg;
    logic                               last_reg, last_next;
    etfc_pkg::phase_t                   phase_out_reg;

    logic                               accept;
    logic signed [etfc_pkg::SAMPLE_W-1:0] sample;
    logic                               below_level;
    logic                               above_level;
    logic                               in_window;
    logic [etfc_pkg::QUIET_W-1:0]       quiet_inc;
    logic                               restart;
    logic [etfc_pkg::POS_W-1:0]         pos_base;
    logic [etfc_pkg::POS_W-1:0]         pos_inc;
    logic [LEN_W-1:0]                   len_floor;
    logic [LEN_W-1:0]                   eff_len;

    // Take a request whenever the result register is free or draining.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Offset-binary to two's complement is a flip of the top bit.
    assign sample = {~adc_code[etfc_pkg::CODE_W-1], adc_code[etfc_pkg::CODE_W-2:0], 6'd0};

    assign below_level = sample < $signed(cfg.trigger_level);
    assign above_level = sample > $signed(cfg.trigger_level);
    assign in_window   = (sample >= $signed(cfg.quiet_low)) &&
                         (sample <= $signed(cfg.quiet_high));
    assign quiet_inc   = quiet_reg + 1'b1;

    // A finished frame is cleared by the first sample after it.
    assign restart  = (phase_reg == etfc_pkg::PH_CAPTURE) && complete_reg;
    assign pos_base = restart ? '0 : pos_reg;
    assign pos_inc  = pos_base + 1'b1;

    // Effective frame length: zero acts as one, clamp at MAX_FRAME.
    assign len_floor = (cfg.frame_length == '0) ? LEN_W'(1) : {1'b0, cfg.frame_length};
    assign eff_len   = (len_floor > MaxLen) ? MaxLen : len_floor;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            etfc_pkg::PH_WAIT_BELOW:
                if (below_level)
                    phase_next = etfc_pkg::PH_WAIT_ABOVE;
            etfc_pkg::PH_WAIT_ABOVE:
                if (above_level)
                    phase_next = etfc_pkg::PH_CAPTURE;
            etfc_pkg::PH_CAPTURE:
                if (complete_reg)
                    phase_next = etfc_pkg::PH_WAIT_QUIET;
            etfc_pkg::PH_WAIT_QUIET:
                if (in_window && (quiet_inc == cfg.quiet_count_needed))
                    phase_next = etfc_pkg::PH_WAIT_BELOW;
            default:
                phase_next = phase_reg;
        endcase
    end

    // Counters and capture outputs
    always_comb
    begin
        quiet_next     = quiet_reg;
        pos_next       = pos_base;
        complete_next  = restart ? 1'b0 : complete_reg;
        cap_valid_next = 1'b0;
        cap_index_next = '0;
        last_next      = 1'b0;

        if (restart)
            quiet_next = '0;
        else if (phase_reg == etfc_pkg::PH_WAIT_QUIET)
            quiet_next = in_window ? quiet_inc : '0;

        // Capture this sample; wrap of the position also ends the frame.
        if (phase_next == etfc_pkg::PH_CAPTURE)
        begin
            cap_valid_next = 1'b1;
            cap_index_next = pos_base[etfc_pkg::INDEX_W-1:0];
            pos_next       = pos_inc;
            if (({1'b0, pos_inc} >= eff_len) || (pos_inc == '0))
            begin
                last_next     = 1'b1;
                complete_next = 1'b1;
            end
        end
    end

    // Hold the result until taken, load a new one on accept.
    assign out_valid_next = accept || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= etfc_pkg::PH_WAIT_BELOW;
            quiet_reg     <= '0;
            pos_reg       <= '0;
            complete_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg    <= phase_next;
                quiet_reg    <= quiet_next;
                pos_reg      <= pos_next;
                complete_reg <= complete_next;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cap_valid_reg <= cap_valid_next;
            cap_index_reg <= cap_index_next;
            sample_reg    <= sample;
            last_reg      <= last_next;
            phase_out_reg <= phase_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign capture_valid = cap_valid_reg;
    assign capture_index = cap_index_reg;
    assign sample_value  = sample_reg;
    assign frame_last    = last_reg;
    assign phase         = phase_out_reg;

endmodule

`default_nettype wire
